[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ACS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define ACS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ACS_ASSERT(lbl, clk, rst_n, prop)

`define ACS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/acs_pkg.sv]
package acs_pkg;

  // Default configuration of the top level.
  localparam int NUM_BUTTONS_DEF          = 8;
  localparam int OVERFLOWS_PER_SECOND_DEF = 128;
  localparam int DEBOUNCE_SAMPLES_DEF     = 8;

  // Buttons that carry an action; higher buttons are ignored.
  localparam int NUM_ACTIONS = 6;

  localparam int BTN_CLEAR        = 0;
  localparam int BTN_ADD_MINUTE   = 1;
  localparam int BTN_ADD_HOUR     = 2;
  localparam int BTN_ALARM_TOGGLE = 3;
  localparam int BTN_ADD_AMINUTE  = 4;
  localparam int BTN_ADD_AHOUR    = 5;

  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [4:0] HOUR_TWO_DIGITS = 5'd10;

  localparam logic [7:0] DARK_CODE   = 8'hFF;
  localparam logic [7:0] COLON_RESET = 8'hFC;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  typedef enum logic [2:0] {
    POS_MIN_ONES  = 3'd0,
    POS_MIN_TENS  = 3'd1,
    POS_COLON     = 3'd2,
    POS_HOUR_ONES = 3'd3,
    POS_HOUR_TENS = 3'd4
  } pos_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_on;
    logic       colon_on;
  } time_t;

  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(logic [5:0] v);
    logic [5:0] t;
    t = {2'b00, tens_of(v)};
    return 4'(v - (t << 3) - (t << 1));
  endfunction

  function automatic logic [7:0] seg_of(logic [3:0] d);
    logic [7:0] code;
    if (d <= 4'd9) code = SEG_TABLE[d];
    else code = DARK_CODE;
    return code;
  endfunction

endpackage

[design/alarm_clock_scan_controller.sv]
// Alarm clock scan controller: each request is one display scan pass carrying the raw
// button levels and a timer-overflow flag, and yields one result with the segment code
// for the position driven and the clock and alarm state after the pass. A request is
// taken every clock while results are consumed. A request is held in the input register,
// and its result is held in the result register. While a result waits to be consumed,
// one more request is taken into the input register; after that the input stalls until
// the result is taken. The colon pattern register may be written only while idle.
`include "assert_macros.svh"

module alarm_clock_scan_controller import acs_pkg::*; #(
  parameter int NUM_BUTTONS          = NUM_BUTTONS_DEF,
  parameter int OVERFLOWS_PER_SECOND = OVERFLOWS_PER_SECOND_DEF,
  parameter int DEBOUNCE_SAMPLES     = DEBOUNCE_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] buttons_raw_i,
  input  logic       timer_overflow_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] segment_code_o,
  output logic [2:0] digit_select_o,
  output logic [4:0] hours_now_o,
  output logic [5:0] minutes_now_o,
  output logic [5:0] seconds_now_o,
  output logic [4:0] alarm_hour_out_o,
  output logic [5:0] alarm_minute_out_o,
  output logic       alarm_armed_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic                   in_valid_q;
  logic [NUM_BUTTONS-1:0] buttons_q;
  logic                   overflow_q;
  logic                   out_valid_q;
  logic [7:0]             colon_pattern_q;
  logic                   step;
  logic [NUM_ACTIONS-1:0] fire;
  time_t                  time_next;
  logic [7:0]             code;
  logic [2:0]             pos;

  logic [7:0] code_q;
  logic [2:0] pos_q;
  time_t      time_q;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      colon_pattern_q <= COLON_RESET;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) colon_pattern_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      buttons_q  <= buttons_raw_i[NUM_BUTTONS-1:0];
      overflow_q <= timer_overflow_i;
    end
    if (step) begin
      code_q <= code;
      pos_q  <= pos;
      time_q <= time_next;
    end
  end

  acs_debounce #(
    .NumButtons      (NUM_BUTTONS),
    .DebounceSamples (DEBOUNCE_SAMPLES)
  ) u_debounce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .raw_i  (buttons_q),
    .fire_o (fire)
  );

  acs_timekeep #(
    .OverflowsPerSecond (OVERFLOWS_PER_SECOND)
  ) u_timekeep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .overflow_i (overflow_q),
    .fire_i     (fire),
    .time_o     (time_next)
  );

  acs_display u_display (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .time_i          (time_next),
    .colon_pattern_i (colon_pattern_q),
    .code_o          (code),
    .pos_o           (pos)
  );

  assign out_valid_o        = out_valid_q;
  assign segment_code_o     = code_q;
  assign digit_select_o     = pos_q;
  assign hours_now_o        = time_q.hour;
  assign minutes_now_o      = time_q.minute;
  assign seconds_now_o      = time_q.second;
  assign alarm_hour_out_o   = time_q.alarm_hour;
  assign alarm_minute_out_o = time_q.alarm_minute;
  assign alarm_armed_o      = time_q.alarm_on;

  `ACS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_q |-> in_ready_o)
  `ACS_ASSERT(a_step_fills_result, clk_i, rst_ni, step |=> out_valid_q)
  `ACS_ASSERT_NEVER(a_step_without_item, clk_i, rst_ni, step && !in_valid_q)

endmodule

[design/acs_debounce.sv]
module acs_debounce import acs_pkg::*; #(
  parameter int NumButtons      = NUM_BUTTONS_DEF,
  parameter int DebounceSamples = DEBOUNCE_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [NumButtons-1:0]  raw_i,
  output logic [NUM_ACTIONS-1:0] fire_o
);

  localparam logic [DebounceSamples:0] FirePattern = {1'b1, {DebounceSamples{1'b0}}};

  logic [DebounceSamples:0] hist_q [NumButtons];
  logic [DebounceSamples:0] hist_d [NumButtons];
  logic [NumButtons-1:0]    fire;

  // A button fires once: high in the oldest sample, low in all newer ones.
  always_comb begin
    for (int b = 0; b < NumButtons; b++) begin
      hist_d[b] = {hist_q[b][DebounceSamples-1:0], raw_i[b]};
      fire[b]   = (hist_d[b] == FirePattern);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumButtons; b++) begin
        hist_q[b] <= '0;
      end
    end else if (step_i) begin
      for (int b = 0; b < NumButtons; b++) begin
        hist_q[b] <= hist_d[b];
      end
    end
  end

  assign fire_o = fire[NUM_ACTIONS-1:0];

endmodule

[design/acs_timekeep.sv]
`include "assert_macros.svh"

module acs_timekeep import acs_pkg::*; #(
  parameter int OverflowsPerSecond = OVERFLOWS_PER_SECOND_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   overflow_i,
  input  logic [NUM_ACTIONS-1:0] fire_i,
  output time_t                  time_o
);

  localparam int PrescaleW = (OverflowsPerSecond > 1) ? $clog2(OverflowsPerSecond) : 1;
  localparam logic [PrescaleW:0] PrescaleTop = (PrescaleW + 1)'(OverflowsPerSecond);

  logic [PrescaleW-1:0] pre_q, pre_d;
  logic [PrescaleW:0]   pre_inc, pre_now;
  logic                 tick;
  time_t                time_q, time_d;

  logic [5:0] sec_a, min_a, min_b, amin_a;
  logic [4:0] hour_a, hour_b, ahour_a, ahour_b;
  logic       sec_c, min_c, amin_c, clr;

  always_comb begin
    pre_inc = {1'b0, pre_q} + 1'b1;
    pre_now = {1'b0, pre_q};
    tick    = overflow_i && (pre_inc >= PrescaleTop);
    if (!overflow_i) pre_d = pre_q;
    else if (tick) pre_d = '0;
    else pre_d = pre_inc[PrescaleW-1:0];

    clr = fire_i[BTN_CLEAR];

    // The clear button acts first, the add buttons after it in the same pass.
    sec_a   = time_q.second + {5'd0, tick};
    min_a   = (clr ? 6'd0 : time_q.minute) + {5'd0, fire_i[BTN_ADD_MINUTE]};
    hour_a  = (clr ? 5'd0 : time_q.hour) + {4'd0, fire_i[BTN_ADD_HOUR]};
    amin_a  = (clr ? 6'd0 : time_q.alarm_minute) + {5'd0, fire_i[BTN_ADD_AMINUTE]};
    ahour_a = (clr ? 5'd0 : time_q.alarm_hour) + {4'd0, fire_i[BTN_ADD_AHOUR]};

    // A button minute and a second carry both add to the minute in the same pass.
    sec_c  = sec_a > SECOND_MAX;
    min_b  = min_a + {5'd0, sec_c};
    min_c  = min_b > MINUTE_MAX;
    hour_b = hour_a + {4'd0, min_c};
    amin_c = amin_a > MINUTE_MAX;
    ahour_b = ahour_a + {4'd0, amin_c};

    time_d.second       = sec_c ? 6'd0 : sec_a;
    time_d.minute       = min_c ? 6'd0 : min_b;
    time_d.hour         = (hour_b > HOUR_MAX) ? 5'd0 : hour_b;
    time_d.alarm_minute = amin_c ? 6'd0 : amin_a;
    time_d.alarm_hour   = (ahour_b > HOUR_MAX) ? 5'd0 : ahour_b;
    time_d.alarm_on     = (clr ? 1'b0 : time_q.alarm_on) ^ fire_i[BTN_ALARM_TOGGLE];
    time_d.colon_on     = time_q.colon_on ^ tick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      time_q <= '0;
    end else if (step_i) begin
      pre_q  <= pre_d;
      time_q <= time_d;
    end
  end

  assign time_o = time_d;

  `ACS_ASSERT(a_time_range, clk_i, rst_ni, time_q.second <= SECOND_MAX && time_q.minute <= MINUTE_MAX && time_q.hour <= HOUR_MAX)
  `ACS_ASSERT(a_alarm_range, clk_i, rst_ni, time_q.alarm_minute <= MINUTE_MAX && time_q.alarm_hour <= HOUR_MAX)
  `ACS_ASSERT(a_prescale_range, clk_i, rst_ni, pre_now < PrescaleTop)

endmodule

[design/acs_display.sv]
`include "assert_macros.svh"

module acs_display import acs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  time_t      time_i,
  input  logic [7:0] colon_pattern_i,
  output logic [7:0] code_o,
  output logic [2:0] pos_o
);

  pos_e scan_q, scan_d;

  always_comb begin
    case (scan_q)
      POS_MIN_ONES:  code_o = seg_of(ones_of(time_i.minute));
      POS_MIN_TENS:  code_o = seg_of(tens_of(time_i.minute));
      POS_HOUR_ONES: code_o = seg_of(ones_of({1'b0, time_i.hour}));
      POS_HOUR_TENS: code_o = seg_of(tens_of({1'b0, time_i.hour}));
      default:       code_o = time_i.colon_on ? colon_pattern_i : DARK_CODE;
    endcase

    // The hour-tens position is skipped while the hour has one digit.
    case (scan_q)
      POS_MIN_ONES:  scan_d = POS_MIN_TENS;
      POS_MIN_TENS:  scan_d = POS_COLON;
      POS_COLON:     scan_d = POS_HOUR_ONES;
      POS_HOUR_ONES: scan_d = (time_i.hour < HOUR_TWO_DIGITS) ? POS_MIN_ONES : POS_HOUR_TENS;
      default:       scan_d = POS_MIN_ONES;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= POS_MIN_ONES;
    end else if (step_i) begin
      scan_q <= scan_d;
    end
  end

  assign pos_o = scan_q;

  `ACS_ASSERT(a_skip_hour_tens, clk_i, rst_ni, step_i && scan_q == POS_HOUR_ONES && time_i.hour < HOUR_TWO_DIGITS |=> scan_q == POS_MIN_ONES)
  `ACS_ASSERT(a_scan_holds, clk_i, rst_ni, !step_i |=> $stable(scan_q))

endmodule
